### src/htd_pkg.sv
// Shared types and constants for the two-zone heater thermostat with dwell timer.
`default_nettype none

package htd_pkg;

  // Control phase of the thermostat, as reported on the mode output.
  typedef enum logic [2:0] {
    PH_IDLE         = 3'd0,
    PH_CONFIRM_LOW  = 3'd1,
    PH_HEATING      = 3'd2,
    PH_CONFIRM_HIGH = 3'd3
  } phase_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_LIMIT_TEMP  = 2'd0,
    REG_HYSTERESIS  = 2'd1,
    REG_DWELL_TICKS = 2'd2
  } cfg_reg_e;

  // Control bits of the thermostat state.
  typedef struct packed {
    phase_e phase;
    logic   zone_sel;
    logic   heat_drive;
    logic   low_flag;
  } htd_ctrl_t;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int DWELL_RESET    = 100 * 60 * 1;

endpackage

`default_nettype wire

### src/htd_next.sv
// Next-state logic of the thermostat for one tick.
`default_nettype none

module htd_next #(
  parameter int TEMP_BITS  = 16,
  parameter int DWELL_BITS = 16
) (
  input  htd_pkg::htd_ctrl_t    ctrl_i,
  input  logic [DWELL_BITS-1:0] count_i,
  input  logic [TEMP_BITS-1:0]  latched_i,
  input  logic [TEMP_BITS-1:0]  zone1_i,
  input  logic [TEMP_BITS-1:0]  zone2_i,
  input  logic                  enable_i,
  input  logic [TEMP_BITS-1:0]  limit_i,
  input  logic [TEMP_BITS-2:0]  hyst_i,
  input  logic [DWELL_BITS-1:0] dwell_i,
  output htd_pkg::htd_ctrl_t    ctrl_o,
  output logic [DWELL_BITS-1:0] count_o,
  output logic [TEMP_BITS-1:0]  latched_o,
  output logic                  done_o
);
  import htd_pkg::*;

  logic [TEMP_BITS-1:0]     cur;
  logic signed [TEMP_BITS:0] cur_s;
  logic signed [TEMP_BITS:0] z1_s;
  logic signed [TEMP_BITS:0] z2_s;
  logic signed [TEMP_BITS:0] lim_s;
  logic signed [TEMP_BITS:0] high_s;
  logic                      count_le1;

  always_comb begin
    cur       = ctrl_i.zone_sel ? zone2_i : zone1_i;
    cur_s     = $signed({cur[TEMP_BITS-1], cur});
    z1_s      = $signed({zone1_i[TEMP_BITS-1], zone1_i});
    z2_s      = $signed({zone2_i[TEMP_BITS-1], zone2_i});
    lim_s     = $signed({limit_i[TEMP_BITS-1], limit_i});
    // Full-width threshold: a sum past the sample range never ends heating
    high_s    = lim_s + $signed({2'b00, hyst_i});
    count_le1 = (count_i <= DWELL_BITS'(1));
  end

  always_comb begin
    ctrl_o    = ctrl_i;
    count_o   = count_i;
    latched_o = latched_i;
    done_o    = 1'b0;

    if (!enable_i) begin
      ctrl_o.phase      = PH_IDLE;
      ctrl_o.heat_drive = 1'b0;
      ctrl_o.low_flag   = 1'b0;
      count_o           = '0;
    end else begin
      unique case (ctrl_i.phase)
        PH_CONFIRM_LOW: begin
          if (cur_s >= lim_s) begin
            ctrl_o.phase      = PH_IDLE;
            ctrl_o.heat_drive = 1'b0;
            ctrl_o.low_flag   = 1'b0;
            count_o           = '0;
          end else if (count_le1) begin
            ctrl_o.phase      = PH_HEATING;
            ctrl_o.heat_drive = 1'b1;
            ctrl_o.low_flag   = 1'b1;
            count_o           = '0;
          end else begin
            count_o = count_i - DWELL_BITS'(1);
          end
        end
        PH_HEATING: begin
          if (cur_s >= high_s) begin
            ctrl_o.phase = PH_CONFIRM_HIGH;
            count_o      = dwell_i;
          end
        end
        PH_CONFIRM_HIGH: begin
          if (cur_s < high_s) begin
            // dip during the off dwell: back to heating
            ctrl_o.phase = PH_HEATING;
            count_o      = '0;
          end else if (count_le1) begin
            ctrl_o.phase      = PH_IDLE;
            ctrl_o.heat_drive = 1'b0;
            ctrl_o.low_flag   = 1'b0;
            count_o           = '0;
            done_o            = 1'b1;
          end else begin
            count_o = count_i - DWELL_BITS'(1);
          end
        end
        default: begin
          ctrl_o.phase = PH_IDLE;
          // zone two wins when both zones are low
          if (z2_s < lim_s) begin
            ctrl_o.zone_sel = 1'b1;
            latched_o       = zone2_i;
            ctrl_o.phase    = PH_CONFIRM_LOW;
            count_o         = dwell_i;
          end else if (z1_s < lim_s) begin
            ctrl_o.zone_sel = 1'b0;
            latched_o       = zone1_i;
            ctrl_o.phase    = PH_CONFIRM_LOW;
            count_o         = dwell_i;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/heater_thermostat_dwell_core.sv
// Two-zone heater thermostat with hysteresis and dwell timer, top level.
// Usage:
//   Each input transaction (zone1_temp_i, zone2_temp_i, enable_i) is one tick
//   of the timebase and yields exactly one result transaction showing the
//   state after that tick: heater drive, low temperature flag, latched zone
//   and temperature, end-of-cycle pulse and mode.
//   The input transaction lands in an input register; once the result slot
//   is free, the threshold compares and dwell counter update run in one pass
//   and load the state and result registers. Throughput is one transaction
//   per cycle while the receiver does not stall.
//   When the receiver stalls, the result is held and the input register keeps
//   one further transaction; in_ready_o drops only when both are occupied.
//   Configuration writes (limit, hysteresis, dwell) are taken every cycle on
//   a separate channel; index 3 is ignored; the data is truncated per register.
//   Reset clears the state to idle with the heater off, limit and hysteresis
//   to zero and dwell to 6000 ticks.
`default_nettype none

module heater_thermostat_dwell_core #(
  parameter int TEMP_BITS  = 16,
  parameter int DWELL_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [htd_pkg::CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [htd_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [TEMP_BITS-1:0]            zone1_temp_i,
  input  logic signed [TEMP_BITS-1:0]            zone2_temp_i,
  input  logic                                   enable_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   heater_drive_o,
  output logic                                   low_temp_flag_o,
  output logic                                   active_zone_o,
  output logic signed [TEMP_BITS-1:0]            trigger_temp_o,
  output logic                                   cycle_done_o,
  output logic [2:0]                             mode_o
);
  import htd_pkg::*;

  // configuration registers
  logic [TEMP_BITS-1:0]  limit_q;
  logic [TEMP_BITS-2:0]  hyst_q;
  logic [DWELL_BITS-1:0] dwell_q;

  // input register
  logic                 in_vld_q;
  logic [TEMP_BITS-1:0] zone1_q;
  logic [TEMP_BITS-1:0] zone2_q;
  logic                 enable_q;

  // state, which doubles as the result register
  htd_ctrl_t             ctrl_q,    ctrl_d;
  logic [DWELL_BITS-1:0] count_q,   count_d;
  logic [TEMP_BITS-1:0]  latched_q, latched_d;
  logic                  done_q,    done_d;
  logic                  out_vld_q;

  logic advance;
  logic in_fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
      hyst_q  <= '0;
      dwell_q <= DWELL_BITS'(DWELL_RESET);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LIMIT_TEMP:  limit_q <= cfg_data_i[TEMP_BITS-1:0];
        REG_HYSTERESIS:  hyst_q  <= cfg_data_i[TEMP_BITS-2:0];
        REG_DWELL_TICKS: dwell_q <= cfg_data_i[DWELL_BITS-1:0];
        default: ;
      endcase
    end
  end

  // advance the computing stage when the result slot is free or being taken
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_fire) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      zone1_q  <= zone1_temp_i;
      zone2_q  <= zone2_temp_i;
      enable_q <= enable_i;
    end
  end

  htd_next #(
    .TEMP_BITS (TEMP_BITS),
    .DWELL_BITS(DWELL_BITS)
  ) u_next (
    .ctrl_i   (ctrl_q),
    .count_i  (count_q),
    .latched_i(latched_q),
    .zone1_i  (zone1_q),
    .zone2_i  (zone2_q),
    .enable_i (enable_q),
    .limit_i  (limit_q),
    .hyst_i   (hyst_q),
    .dwell_i  (dwell_q),
    .ctrl_o   (ctrl_d),
    .count_o  (count_d),
    .latched_o(latched_d),
    .done_o   (done_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= '{phase: PH_IDLE, zone_sel: 1'b0, heat_drive: 1'b0, low_flag: 1'b0};
      count_q   <= '0;
      latched_q <= '0;
      done_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        ctrl_q    <= ctrl_d;
        count_q   <= count_d;
        latched_q <= latched_d;
        done_q    <= done_d;
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign heater_drive_o  = ctrl_q.heat_drive;
  assign low_temp_flag_o = ctrl_q.low_flag;
  assign active_zone_o   = ctrl_q.zone_sel;
  assign trigger_temp_o  = latched_q;
  assign cycle_done_o    = done_q;
  assign mode_o          = ctrl_q.phase;

endmodule

`default_nettype wire
